[rtl/sgf_pkg.sv]
// Shared types, widths and codes for the sample stream gap filler.
package sgf_pkg;

   // Field and internal widths
   localparam int SAMPLE_W   = 32;
   localparam int TIME_W     = 48;
   localparam int PERIOD_W   = 20;
   localparam int CFG_W      = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int FILL_W     = 6;
   localparam int DEN_W      = FILL_W + 1;
   localparam int GAP_W      = TIME_W + 2;
   localparam int DVD_W      = SAMPLE_W + 1;
   localparam int DVS_W      = PERIOD_W;
   localparam int DIV_CNT_W  = 6;
   localparam int ACC_W      = SAMPLE_W + 2;

   // Fill length cap default
   localparam int MAX_GAP_FILL_DEF = 63;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_GAP_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAP_TOLERANCE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INTERP_ENABLE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SAT_ENABLE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SAT_THRESHOLD = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WARMUP        = 3'd5;

   localparam logic [CFG_W-1:0] SAT_THRESHOLD_RESET = 32'h8000_0000;

   // Input item
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic [TIME_W-1:0]          time_us;
      logic [PERIOD_W-1:0]        sample_period_us;
      logic                       first_in_record;
   } req_data_type;

   // Result item
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] value;
      logic                       interpolated;
      logic                       settled;
      logic                       gap_unfilled;
      logic                       clipped;
      logic                       last_of_run;
   } rsp_data_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic check;
      logic set_unfilled;
      logic set_dropping;
      logic start_stream;
      logic div_start;
      logic div_sel_den;
      logic take_n;
      logic take_d;
      logic fill_step;
      logic sel_fill;
      logic emit;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic finished;
      logic first;
      logic dropping;
      logic do_gap;
      logic gap_gt_eff;
      logic fill_ok;
      logic overlap;
      logic div_done;
      logic has_fill;
      logic k_last;
      logic out_free;
      logic clip;
   } dp_status_type;

endpackage

[rtl/sgf_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
module sgf_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [sgf_pkg::DVD_W-1:0]    dividend,
   input  logic [sgf_pkg::DVS_W-1:0]    divisor,
   output logic                         done,
   output logic [sgf_pkg::DVD_W-1:0]    quotient,
   output logic [sgf_pkg::DVS_W-1:0]    remainder
);
   import sgf_pkg::*;

   logic [DVD_W-1:0]     quo_ff, quo_in;
   logic [DVS_W-1:0]     rem_ff, rem_in;
   logic [DVS_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DVS_W:0]       shifted;
   logic [DVS_W:0]       diff;
   logic                 ge;

   // One shift-subtract step
   always_comb begin
      shifted = {rem_ff, quo_ff[DVD_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      ge      = (shifted >= {1'b0, dvs_ff});
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

[rtl/sgf_dp.sv]
// Datapath: registers, stream state, gap arithmetic, fill generator, result register.
module sgf_dp #(
   parameter int MAX_GAP_FILL = sgf_pkg::MAX_GAP_FILL_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  sgf_pkg::req_data_type           req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output sgf_pkg::rsp_data_type           rsp_data,
   input  logic                            csr_we,
   input  logic [sgf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sgf_pkg::CFG_W-1:0]       csr_wdata,
   input  sgf_pkg::ctrl_cmd_type           cmd,
   output sgf_pkg::dp_status_type          status
);
   import sgf_pkg::*;

   // Configuration
   logic [CFG_W-1:0] gap_thr_ff, gap_thr_in;
   logic [CFG_W-1:0] gap_tol_ff, gap_tol_in;
   logic             interp_en_ff, interp_en_in;
   logic             sat_en_ff, sat_en_in;
   logic [CFG_W-1:0] sat_thr_ff, sat_thr_in;
   logic [CFG_W-1:0] warmup_ff, warmup_in;

   // Current item
   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic [TIME_W-1:0]          t_ff, t_in;
   logic [PERIOD_W-1:0]        p_ff, p_in;
   logic                       first_ff, first_in;

   // Stream state
   logic                       open_ff, open_in;
   logic signed [SAMPLE_W-1:0] prev_ff, prev_in;
   logic [TIME_W-1:0]          prev_t_ff, prev_t_in;
   logic [PERIOD_W-1:0]        period_ff, period_in;
   logic [CFG_W-1:0]           eff_ff, eff_in;
   logic [CFG_W-1:0]           count_ff, count_in;
   logic                       dropping_ff, dropping_in;
   logic                       finished_ff, finished_in;

   // Per-item work
   logic                       unfilled_ff, unfilled_in;
   logic                       do_gap_ff, do_gap_in;
   logic [GAP_W-1:0]           gap_ff, gap_in;
   logic [FILL_W-1:0]          nfill_ff, nfill_in;
   logic signed [ACC_W-1:0]    qf_ff, qf_in;
   logic [DEN_W-1:0]           rf_ff, rf_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic [DEN_W-1:0]           rem_ff, rem_in;
   logic [FILL_W-1:0]          k_ff, k_in;

   // Result register
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_data_type               rsp_ff, rsp_in;

   // Combinational helpers
   logic [GAP_W-1:0]           gap_calc;
   logic                       gap_neg;
   logic [GAP_W-1:0]           gap_mag;
   logic [DEN_W-1:0]           den;
   logic [DVD_W-1:0]           delta;
   logic [DVD_W-1:0]           delta_mag;
   logic [DVD_W-1:0]           div_dvd;
   logic [DVS_W-1:0]           div_dvs;
   logic                       div_done;
   logic [DVD_W-1:0]           div_quo;
   logic [DVS_W-1:0]           div_rem;
   logic [DEN_W-1:0]           div_r;
   logic signed [ACC_W-1:0]    qpos;
   logic [DEN_W:0]             rsum;
   logic                       wrap;
   logic signed [ACC_W-1:0]    fill_v;
   logic signed [SAMPLE_W-1:0] cand;
   logic [SAMPLE_W-1:0]        mag;
   logic                       clip;
   logic [CFG_W-1:0]           count_next;
   logic [CFG_W-1:0]           eff_a;
   logic [CFG_W-1:0]           two_p;
   logic                       out_free;

   // Shared divider: fill length at a gap, then the slope of the fill
   sgf_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Gap, overlap, fill arithmetic
   always_comb begin
      gap_calc  = {2'b00, t_ff} - {2'b00, prev_t_ff} - GAP_W'(period_ff) - GAP_W'(1);
      gap_neg   = gap_ff[GAP_W-1];
      gap_mag   = -gap_ff;
      den       = DEN_W'(nfill_ff) + DEN_W'(1);
      delta     = {x_ff[SAMPLE_W-1], x_ff} - {prev_ff[SAMPLE_W-1], prev_ff};
      delta_mag = delta[DVD_W-1] ? -delta : delta;
      if (cmd.div_sel_den) begin
         div_dvd = delta_mag;
         div_dvs = DVS_W'(den);
      end else begin
         div_dvd = DVD_W'(gap_ff[SAMPLE_W-1:0]) + DVD_W'(period_ff) - DVD_W'(1);
         div_dvs = period_ff;
      end
      div_r  = div_rem[DEN_W-1:0];
      qpos   = ACC_W'(div_quo);
      rsum   = {1'b0, rem_ff} + {1'b0, rf_ff};
      wrap   = (rsum >= {1'b0, den});
      // Floor quotient plus remainder; bump toward zero when negative and inexact
      fill_v = acc_ff + ((acc_ff[ACC_W-1] && (rem_ff != '0)) ? ACC_W'(1) : ACC_W'(0));
      cand   = cmd.sel_fill ? fill_v[SAMPLE_W-1:0] : x_ff;
      mag    = cand[SAMPLE_W-1] ? (~cand + SAMPLE_W'(1)) : cand;
      clip   = sat_en_ff && (mag >= sat_thr_ff);
      count_next = (count_ff == '1) ? count_ff : count_ff + CFG_W'(1);
      eff_a  = (gap_thr_ff > eff_ff) ? gap_thr_ff : eff_ff;
      two_p  = CFG_W'({p_ff, 1'b0});
      out_free = !rsp_valid_ff || rsp_ready;
   end

   // Next-state logic
   always_comb begin
      gap_thr_in   = gap_thr_ff;
      gap_tol_in   = gap_tol_ff;
      interp_en_in = interp_en_ff;
      sat_en_in    = sat_en_ff;
      sat_thr_in   = sat_thr_ff;
      warmup_in    = warmup_ff;
      x_in         = x_ff;
      t_in         = t_ff;
      p_in         = p_ff;
      first_in     = first_ff;
      open_in      = open_ff;
      prev_in      = prev_ff;
      prev_t_in    = prev_t_ff;
      period_in    = period_ff;
      eff_in       = eff_ff;
      count_in     = count_ff;
      dropping_in  = dropping_ff;
      finished_in  = finished_ff;
      unfilled_in  = unfilled_ff;
      do_gap_in    = do_gap_ff;
      gap_in       = gap_ff;
      nfill_in     = nfill_ff;
      qf_in        = qf_ff;
      rf_in        = rf_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      k_in         = k_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      // Register writes
      if (csr_we) begin
         case (csr_index)
            REG_GAP_THRESHOLD: gap_thr_in   = csr_wdata;
            REG_GAP_TOLERANCE: gap_tol_in   = csr_wdata;
            REG_INTERP_ENABLE: interp_en_in = csr_wdata[0];
            REG_SAT_ENABLE:    sat_en_in    = csr_wdata[0];
            REG_SAT_THRESHOLD: sat_thr_in   = csr_wdata;
            REG_WARMUP:        warmup_in    = csr_wdata;
            default: ;
         endcase
      end

      // Capture item; a zero period counts as one
      if (cmd.load) begin
         x_in        = req_data.sample;
         t_in        = req_data.time_us;
         p_in        = (req_data.sample_period_us == '0) ? PERIOD_W'(1)
                                                          : req_data.sample_period_us;
         first_in    = req_data.first_in_record;
         unfilled_in = 1'b0;
         nfill_in    = '0;
      end

      // Record start: period change closes the stream
      if (cmd.check) begin
         gap_in    = gap_calc;
         do_gap_in = first_ff && open_ff && (p_ff == period_ff);
         if (first_ff) begin
            dropping_in = 1'b0;
            if (open_ff && (p_ff != period_ff)) begin
               open_in = 1'b0;
            end
         end
      end

      if (cmd.set_unfilled) begin
         unfilled_in = 1'b1;
      end

      if (cmd.set_dropping) begin
         dropping_in = 1'b1;
      end

      // New stream: threshold raised, sticky
      if (cmd.start_stream && !open_ff) begin
         eff_in    = (two_p > eff_a) ? two_p : eff_a;
         period_in = p_ff;
         open_in   = 1'b1;
      end

      if (cmd.take_n) begin
         nfill_in = (div_quo > DVD_W'(MAX_GAP_FILL)) ? FILL_W'(MAX_GAP_FILL)
                                                      : div_quo[FILL_W-1:0];
      end

      // Floor-divided slope
      if (cmd.take_d) begin
         if (delta[DVD_W-1]) begin
            if (div_r != '0) begin
               qf_in = -qpos - ACC_W'(1);
               rf_in = den - div_r;
            end else begin
               qf_in = -qpos;
               rf_in = '0;
            end
         end else begin
            qf_in = qpos;
            rf_in = div_r;
         end
         acc_in = ACC_W'(prev_ff);
         rem_in = '0;
         k_in   = '0;
      end

      // Step to the next fill point
      if (cmd.fill_step) begin
         if (wrap) begin
            rem_in = rsum[DEN_W-1:0] - den;
            acc_in = acc_ff + qf_ff + ACC_W'(1);
         end else begin
            rem_in = rsum[DEN_W-1:0];
            acc_in = acc_ff + qf_ff;
         end
         k_in = k_ff + FILL_W'(1);
      end

      // Result out
      if (cmd.emit) begin
         rsp_valid_in        = 1'b1;
         rsp_in.value        = cand;
         rsp_in.interpolated = cmd.sel_fill;
         rsp_in.settled      = (count_next > warmup_ff);
         rsp_in.gap_unfilled = !cmd.sel_fill && unfilled_ff;
         rsp_in.clipped      = clip;
         rsp_in.last_of_run  = !cmd.sel_fill || clip;
         count_in            = count_next;
         if (clip) begin
            finished_in = 1'b1;
         end
         if (!cmd.sel_fill) begin
            prev_in   = x_ff;
            prev_t_in = t_ff;
         end
      end
   end

   // Control and stream state
   always_ff @(posedge clock) begin
      if (reset) begin
         gap_thr_ff   <= '0;
         gap_tol_ff   <= '0;
         interp_en_ff <= 1'b0;
         sat_en_ff    <= 1'b0;
         sat_thr_ff   <= SAT_THRESHOLD_RESET;
         warmup_ff    <= '0;
         open_ff      <= 1'b0;
         prev_ff      <= '0;
         prev_t_ff    <= '0;
         period_ff    <= '0;
         eff_ff       <= '0;
         count_ff     <= '0;
         dropping_ff  <= 1'b0;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gap_thr_ff   <= gap_thr_in;
         gap_tol_ff   <= gap_tol_in;
         interp_en_ff <= interp_en_in;
         sat_en_ff    <= sat_en_in;
         sat_thr_ff   <= sat_thr_in;
         warmup_ff    <= warmup_in;
         open_ff      <= open_in;
         prev_ff      <= prev_in;
         prev_t_ff    <= prev_t_in;
         period_ff    <= period_in;
         eff_ff       <= eff_in;
         count_ff     <= count_in;
         dropping_ff  <= dropping_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      t_ff        <= t_in;
      p_ff        <= p_in;
      first_ff    <= first_in;
      unfilled_ff <= unfilled_in;
      do_gap_ff   <= do_gap_in;
      gap_ff      <= gap_in;
      nfill_ff    <= nfill_in;
      qf_ff       <= qf_in;
      rf_ff       <= rf_in;
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      k_ff        <= k_in;
      rsp_ff      <= rsp_in;
   end

   // Status to controller
   always_comb begin
      status.finished   = finished_ff;
      status.first      = first_ff;
      status.dropping   = dropping_ff;
      status.do_gap     = do_gap_ff;
      status.gap_gt_eff = !gap_neg && (gap_ff > GAP_W'(eff_ff));
      status.fill_ok    = interp_en_ff && (gap_ff <= GAP_W'(gap_tol_ff));
      status.overlap    = gap_neg && (gap_mag > GAP_W'(period_ff));
      status.div_done   = div_done;
      status.has_fill   = (nfill_ff != '0);
      status.k_last     = (k_ff == nfill_ff);
      status.out_free   = out_free;
      status.clip       = clip;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/sgf_ctrl.sv]
// Controller state machine: sequences check, divide, fill and emit per item.
module sgf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sgf_pkg::dp_status_type status,
   output sgf_pkg::ctrl_cmd_type  cmd
);
   import sgf_pkg::*;

   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
   localparam logic [ST_W-1:0] ST_CHECK = 4'd1;
   localparam logic [ST_W-1:0] ST_EVAL  = 4'd2;
   localparam logic [ST_W-1:0] ST_DIVN  = 4'd3;
   localparam logic [ST_W-1:0] ST_START = 4'd4;
   localparam logic [ST_W-1:0] ST_DIVD  = 4'd5;
   localparam logic [ST_W-1:0] ST_FILL  = 4'd6;
   localparam logic [ST_W-1:0] ST_FEMIT = 4'd7;
   localparam logic [ST_W-1:0] ST_EMIT  = 4'd8;

   logic [ST_W-1:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         // Wait for an item
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         // Drop after clipping, or inside a dropped record
         ST_CHECK: begin
            if (status.finished || (!status.first && status.dropping)) begin
               state_in = ST_IDLE;
            end else begin
               cmd.check = 1'b1;
               state_in  = ST_EVAL;
            end
         end
         // Gap decision at a record start
         ST_EVAL: begin
            if (status.do_gap && status.gap_gt_eff) begin
               if (status.fill_ok) begin
                  cmd.div_start = 1'b1;
                  state_in      = ST_DIVN;
               end else begin
                  cmd.set_unfilled = 1'b1;
                  state_in         = ST_START;
               end
            end else if (status.do_gap && status.overlap) begin
               cmd.set_dropping = 1'b1;
               state_in         = ST_IDLE;
            end else begin
               state_in = ST_START;
            end
         end
         // Fill length = ceil(gap / period)
         ST_DIVN: begin
            if (status.div_done) begin
               cmd.take_n = 1'b1;
               state_in   = ST_START;
            end
         end
         // Open stream if closed, then fill or pass
         ST_START: begin
            cmd.start_stream = 1'b1;
            if (status.has_fill) begin
               cmd.div_start   = 1'b1;
               cmd.div_sel_den = 1'b1;
               state_in        = ST_DIVD;
            end else begin
               state_in = ST_EMIT;
            end
         end
         // Slope = delta / (n + 1)
         ST_DIVD: begin
            cmd.div_sel_den = 1'b1;
            if (status.div_done) begin
               cmd.take_d = 1'b1;
               state_in   = ST_FILL;
            end
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            state_in      = ST_FEMIT;
         end
         // One interpolated item
         ST_FEMIT: begin
            cmd.sel_fill = 1'b1;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.clip) begin
                  state_in = ST_IDLE;
               end else if (status.k_last) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_FILL;
               end
            end
         end
         // The sample itself
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/sample_stream_gap_filler_top.sv]
// Top level of the sample stream gap filler: controller plus datapath.
//
//   channel  ports                          width  direction
//   req      req_valid/req_ready/req_data   103    in
//   rsp      rsp_valid/rsp_ready/rsp_data   39     out
//   csr      csr_we/csr_index/csr_wdata     36     in, write only
//
// A sample inside a record steps through the check, evaluate, start and emit
// states from acceptance to its item in the output register, then returns
// to idle for the next item; a record start whose gap is filled adds two divider
// runs plus a fill and an emit step per interpolated item (fill <= 63).
// The 1-bit-per-cycle shared divider sets the gap cost.
// Synchronous active-high reset; no clearing pass.
// A stalled rsp holds the controller in its emit state; the output register
// lets the next input be taken while the last item waits.
module sample_stream_gap_filler_top #(
   parameter int MAX_GAP_FILL = sgf_pkg::MAX_GAP_FILL_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  sgf_pkg::req_data_type           req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output sgf_pkg::rsp_data_type           rsp_data,
   input  logic                            csr_we,
   input  logic [sgf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sgf_pkg::CFG_W-1:0]       csr_wdata
);
   import sgf_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   sgf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sgf_dp #(
      .MAX_GAP_FILL (MAX_GAP_FILL)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
